>>> rtl/core/pid_controller_clamped_decay_macros.svh
// Assertion helpers shared by the PID controller RTL.
`ifndef PID_CONTROLLER_CLAMPED_DECAY_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_DECAY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/pcd_pkg.sv
package pcd_pkg;

  // Operand and product widths of the shared serial multiplier.
  localparam int unsigned MUL_A_W = 49;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Dividend and divisor widths of the serial divider.
  localparam int unsigned DIV_N_W = 49;
  localparam int unsigned DIV_D_W = 31;

  // Integral decay factor 0.95 in Q16.16.
  localparam logic [31:0] DECAY_Q16 = 32'd62259;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_GAIN_P           = 3'd0,
    REG_GAIN_I           = 3'd1,
    REG_GAIN_D           = 3'd2,
    REG_STEP_TIME        = 3'd3,
    REG_INTEGRAL_LIMIT   = 3'd4,
    REG_DERIVATIVE_LIMIT = 3'd5,
    REG_OUTPUT_WEIGHT    = 3'd6,
    REG_LIMIT_ENABLES    = 3'd7
  } cfg_reg_t;

  // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Q16.16 product rescale: shift right by 16, rounding half away from zero.
  function automatic logic [47:0] round_q(logic [63:0] p);
    logic [63:0] t;
    t = p + 64'h8000;
    return t[63:16];
  endfunction

  // Saturate a sign and magnitude pair to signed 32 bits.
  function automatic logic signed [31:0] sat_mag(logic [49:0] m, logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (m > 50'h80000000) ? S32_MIN : -$signed(m[31:0]);
    end else begin
      r = (m > 50'h7fffffff) ? S32_MAX : $signed(m[31:0]);
    end
    return r;
  endfunction

  // Saturate a signed 50-bit value to signed 32 bits.
  function automatic logic signed [31:0] sat_s50(logic signed [49:0] v);
    logic [49:0] m;
    m = v[49] ? 50'(-v) : 50'(v);
    return sat_mag(m, v[49]);
  endfunction

endpackage

>>> rtl/core/pcd_if.sv
// Input channel: one error sample or one clear request per item.
interface pcd_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] error_sample;
  modport source(output valid, mode, error_sample, input ready);
  modport sink(input valid, mode, error_sample, output ready);
endinterface

// Output channel: one controller drive value per item.
interface pcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  modport source(output valid, drive, input ready);
  modport sink(input valid, drive, output ready);
endinterface

>>> rtl/core/pcd_mul.sv
// Shift-add unsigned multiplier, one multiplier bit per cycle.
module pcd_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcd_pkg::MUL_A_W-1:0]   a,
  input  logic [pcd_pkg::MUL_B_W-1:0]   b,
  output logic                          busy,
  output logic                          done,
  output logic [pcd_pkg::MUL_P_W-1:0]   prod
);

  logic [pcd_pkg::MUL_A_W-1:0] mcand;
  logic [4:0]                  cnt;
  logic [pcd_pkg::MUL_A_W:0]   hi_sum;
  logic [pcd_pkg::MUL_P_W-1:0] prod_next;

  // Add the multiplicand into the upper half when the low bit is set, then shift.
  always_comb begin
    hi_sum = {1'b0, prod[pcd_pkg::MUL_P_W-1:pcd_pkg::MUL_B_W]}
           + (prod[0] ? {1'b0, mcand} : '0);
    prod_next = {hi_sum, prod[pcd_pkg::MUL_B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod  <= {{pcd_pkg::MUL_A_W{1'b0}}, b};
        mcand <= a;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        prod <= prod_next;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(pcd_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/pcd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pcd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcd_pkg::DIV_N_W-1:0]   dividend,
  input  logic [pcd_pkg::DIV_D_W-1:0]   divisor,
  output logic                          done,
  output logic [pcd_pkg::DIV_N_W-1:0]   quotient
);

  logic [pcd_pkg::DIV_D_W-1:0] dsr;
  logic [pcd_pkg::DIV_D_W-1:0] rem;
  logic [5:0]                  cnt;
  logic                        busy;
  logic [pcd_pkg::DIV_D_W+1:0] trial;

  // Trial subtract of the divisor from the partial remainder.
  assign trial = {1'b0, rem, quotient[pcd_pkg::DIV_N_W-1]} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        if (!trial[pcd_pkg::DIV_D_W+1]) begin
          rem      <= trial[pcd_pkg::DIV_D_W-1:0];
          quotient <= {quotient[pcd_pkg::DIV_N_W-2:0], 1'b1};
        end else begin
          rem      <= {rem[pcd_pkg::DIV_D_W-2:0], quotient[pcd_pkg::DIV_N_W-1]};
          quotient <= {quotient[pcd_pkg::DIV_N_W-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(pcd_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/pid_controller_clamped_decay.sv
// Channel   Dir  Fields
// in_ch     in   mode, error_sample (signed Q16.16)
// out_ch    out  drive (signed Q16.16)
// cfg_*     in   cfg_we, cfg_index, cfg_data (write only)
//
// An update item runs through the bit-serial derivative divide, then five products
// on the shared serial multiplier, then delivery and the return to idle; no new item
// is accepted before idle, and delivery waits while the output holds an untaken result.
// A first sample skips the divide. A clear item zeroes the integral, stays in idle and gives no result.
// Reset is synchronous; some data registers, such as err, sum and the output drive, are not reset.
// A finished result waits in the output register while the next item runs.
`include "pid_controller_clamped_decay_macros.svh"

module pid_controller_clamped_decay (
  input  logic        clk,
  input  logic        rst,
  pcd_in_if.sink      in_ch,
  pcd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_INTEG, ST_TERM_P, ST_TERM_I, ST_TERM_D, ST_WEIGHT, ST_DELIVER
  } state_t;

  // Configuration registers.
  logic signed [31:0] gain_p, gain_i, gain_d, output_weight;
  logic [30:0]        step_time, integral_limit, derivative_limit;
  logic [1:0]         limit_enables;

  // Controller state and item registers.
  state_t             state;
  logic signed [31:0] err, last_error, integral, deriv;
  logic               started;
  logic               launched;
  logic signed [49:0] sum;
  logic signed [31:0] res_pend;

  // Serial unit hookups.
  logic                          mul_start, mul_busy, mul_done;
  logic [pcd_pkg::MUL_A_W-1:0]   mul_a;
  logic [pcd_pkg::MUL_B_W-1:0]   mul_b;
  logic                          mul_neg;
  logic [pcd_pkg::MUL_P_W-1:0]   mul_prod;
  logic                          div_start, div_done;
  logic [pcd_pkg::DIV_N_W-1:0]   div_quot;

  logic               accept;
  logic signed [31:0] err_cur;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [30:0]        divisor;
  logic               decay;
  logic [47:0]        term_mag;
  logic signed [49:0] term;
  logic signed [49:0] sum_total;
  logic [49:0]        sum_mag;
  logic signed [31:0] deriv_div;
  logic signed [31:0] integ_new;
  logic signed [31:0] weighted;
  logic [48:0]        w_round;
  logic [31:0]        deriv_mag;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);

  // Derivative divide operands. The divide starts on the accepting edge, so the
  // incoming sample is used directly in idle; err and last_error hold after that.
  assign err_cur   = (state == ST_IDLE) ? in_ch.error_sample : err;
  assign diff      = {err_cur[31], err_cur} - {last_error[31], last_error};
  assign diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
  assign divisor   = (step_time == '0) ? 31'd1 : step_time;
  assign div_start = accept && !in_ch.mode && started;

  // Decay replaces accumulation when the integral is above an enabled limit.
  assign decay = limit_enables[0] && (pcd_pkg::mag32(integral) > {1'b0, integral_limit});

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (state)
      ST_INTEG: begin
        mul_a   = {17'b0, pcd_pkg::mag32(err)};
        mul_b   = decay ? pcd_pkg::DECAY_Q16 : {1'b0, step_time};
        mul_neg = err[31];
      end
      ST_TERM_P: begin
        mul_a   = {17'b0, pcd_pkg::mag32(err)};
        mul_b   = pcd_pkg::mag32(gain_p);
        mul_neg = err[31] ^ gain_p[31];
      end
      ST_TERM_I: begin
        mul_a   = {17'b0, pcd_pkg::mag32(integral)};
        mul_b   = pcd_pkg::mag32(gain_i);
        mul_neg = integral[31] ^ gain_i[31];
      end
      ST_TERM_D: begin
        mul_a   = {17'b0, pcd_pkg::mag32(deriv)};
        mul_b   = pcd_pkg::mag32(gain_d);
        mul_neg = deriv[31] ^ gain_d[31];
      end
      ST_WEIGHT: begin
        mul_a   = sum_mag[48:0];
        mul_b   = pcd_pkg::mag32(output_weight);
        mul_neg = sum[49] ^ output_weight[31];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign mul_start = !launched && (state == ST_INTEG || state == ST_TERM_P ||
                     state == ST_TERM_I || state == ST_TERM_D || state == ST_WEIGHT);

  // Rescaled signed product and the values built from it.
  assign term_mag  = pcd_pkg::round_q(mul_prod[63:0]);
  assign term      = mul_neg ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});
  assign sum_total = sum + term;
  assign sum_mag   = sum[49] ? 50'(-sum) : 50'(sum);
  assign integ_new = decay ? pcd_pkg::sat_s50(term)
                           : pcd_pkg::sat_s50(50'(integral) + term);
  assign deriv_div = pcd_pkg::sat_mag({1'b0, div_quot}, diff[32]);
  assign w_round   = {1'b0, mul_prod[47:0]} + 49'h8000;
  assign deriv_mag = pcd_pkg::mag32(deriv);

  // Weighted output: any product bit at 2^48 or above saturates.
  always_comb begin
    if (mul_prod[pcd_pkg::MUL_P_W-1:48] != '0) begin
      weighted = mul_neg ? pcd_pkg::S32_MIN : pcd_pkg::S32_MAX;
    end else begin
      weighted = pcd_pkg::sat_mag({17'b0, w_round[48:16]}, mul_neg);
    end
  end

  // Symmetric clamp of the derivative when enabled.
  function automatic logic signed [31:0] clamp_d(logic signed [31:0] d);
    logic signed [31:0] lim;
    logic signed [31:0] r;
    lim = $signed({1'b0, derivative_limit});
    r   = d;
    if (limit_enables[1]) begin
      if (d > lim) r = lim;
      if (d < -lim) r = -lim;
    end
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      step_time        <= 31'd65536;
      integral_limit   <= 31'h7fffffff;
      derivative_limit <= 31'h7fffffff;
      output_weight    <= 32'sd65536;
      limit_enables    <= '0;
    end else if (cfg_we) begin
      unique case (pcd_pkg::cfg_reg_t'(cfg_index))
        pcd_pkg::REG_GAIN_P:           gain_p           <= cfg_data;
        pcd_pkg::REG_GAIN_I:           gain_i           <= cfg_data;
        pcd_pkg::REG_GAIN_D:           gain_d           <= cfg_data;
        pcd_pkg::REG_STEP_TIME:        step_time        <= cfg_data[30:0];
        pcd_pkg::REG_INTEGRAL_LIMIT:   integral_limit   <= cfg_data[30:0];
        pcd_pkg::REG_DERIVATIVE_LIMIT: derivative_limit <= cfg_data[30:0];
        pcd_pkg::REG_OUTPUT_WEIGHT:    output_weight    <= cfg_data;
        pcd_pkg::REG_LIMIT_ENABLES:    limit_enables    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      started      <= 1'b0;
      launched     <= 1'b0;
      last_error   <= '0;
      integral     <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != ST_DELIVER) begin
        out_ch.valid <= 1'b0;
      end
      if (mul_start) begin
        launched <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.mode) begin
              integral <= '0;
            end else begin
              err <= in_ch.error_sample;
              if (started) begin
                state <= ST_DIV;
              end else begin
                started <= 1'b1;
                deriv   <= '0;
                state   <= ST_INTEG;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            deriv <= clamp_d(deriv_div);
            state <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          if (mul_done) begin
            integral   <= integ_new;
            last_error <= err;
            launched   <= 1'b0;
            state      <= ST_TERM_P;
          end
        end
        ST_TERM_P: begin
          if (mul_done) begin
            sum      <= term;
            launched <= 1'b0;
            state    <= ST_TERM_I;
          end
        end
        ST_TERM_I: begin
          if (mul_done) begin
            sum      <= sum_total;
            launched <= 1'b0;
            state    <= ST_TERM_D;
          end
        end
        ST_TERM_D: begin
          if (mul_done) begin
            sum      <= sum_total;
            launched <= 1'b0;
            state    <= ST_WEIGHT;
          end
        end
        ST_WEIGHT: begin
          if (mul_done) begin
            res_pend <= weighted;
            launched <= 1'b0;
            state    <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.drive <= res_pend;
            out_ch.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  pcd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pcd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_mag, 16'b0}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // A clear item empties the integral and returns straight to idle.
  `PCD_ASSERT_NEXT(a_clear, accept && in_ch.mode, integral == 32'sd0 && state == ST_IDLE, "clear item did not zero the integral")
  // The multiplier is never restarted while a product is in progress.
  `PCD_ASSERT_NOW(a_mul_free, mul_start, !mul_busy, "multiplier started while busy")
  // With the clamp enabled the derivative stays within its bound.
  `PCD_ASSERT_NOW(a_deriv_clamp, state == ST_TERM_P && limit_enables[1], deriv_mag <= {1'b0, derivative_limit}, "derivative outside clamp")

endmodule

>>> tb/pcd_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces are compiled from the RTL tree.
// This file holds the item type that the stimulus queue carries.
package pcd_tb_pkg;
  typedef struct packed {
    logic               mode;
    logic signed [31:0] error_sample;
  } ctl_item_t;
endpackage

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pcd_in_if  in_ch();
  pcd_out_if out_ch();

  pid_controller_clamped_decay uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state and configuration.
  longint kp, ki, kd, weight;
  longint period, int_lim, der_lim;
  logic [1:0] enables;
  longint prev_err, integ;
  bit seen_sample;

  pcd_tb_pkg::ctl_item_t pending_items[$];
  logic signed [31:0] drive_expected[$];
  int  errors;
  bit  calm;
  bit  in_taken;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, rounded half away from zero.
  function automatic longint qmul(longint a, longint b);
    longint m;
    m = (mag(a) * mag(b) + 64'sd32768) >>> 16;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  task automatic predict_drive(input longint e);
    longint diff, div, deriv, sum, m, wm, p, res;
    bit neg;
    deriv = 0;
    if (seen_sample) begin
      diff = e - prev_err;
      div = (period != 0) ? period : 1;
      m = (mag(diff) << 16) / div;
      deriv = sat_s32(diff < 0 ? -m : m);
    end
    seen_sample = 1;
    if (enables[1]) begin
      if (deriv > der_lim) deriv = der_lim;
      if (deriv < -der_lim) deriv = -der_lim;
    end
    if (enables[0] && mag(integ) > int_lim) integ = qmul(e, longint'(pcd_pkg::DECAY_Q16));
    else integ = sat_s32(integ + qmul(e, period));
    prev_err = e;
    sum = qmul(kp, e) + qmul(ki, integ) + qmul(kd, deriv);
    m = mag(sum);
    wm = mag(weight);
    neg = (sum < 0) != (weight < 0);
    if (wm != 0 && m > ((64'sd1 << 48) - 1) / wm) begin
      res = neg ? -64'sd2147483648 : 64'sd2147483647;
    end else begin
      p = (m * wm + 64'sd32768) >>> 16;
      res = sat_s32(neg ? -p : p);
    end
    drive_expected.push_back(res[31:0]);
  endtask

  // Driver: presents queued items, idling at random outside calm stretches.
  // An item counts as taken only when the last rising edge accepted it.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_taken) void'(pending_items.pop_front());
      if (pending_items.size() > (in_taken ? 1 : 0)
          && (calm || $urandom_range(99) >= 31)) begin
        in_ch.valid <= 1'b1;
        in_ch.mode <= pending_items[in_taken ? 1 : 0].mode;
        in_ch.error_sample <= pending_items[in_taken ? 1 : 0].error_sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver side stalls at random too.
  always @(negedge clk) begin
    out_ch.ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 31);
  end

  // Monitor: predicts on each accepted sample, zeroes the integral on a clear, and checks each result.
  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      cycles <= cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode) integ = 0;
        else predict_drive(longint'(in_ch.error_sample));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (drive_expected.size() == 0) begin
          $display("%0t: unexpected drive %0d", $time, out_ch.drive);
          errors++;
        end else begin
          if (out_ch.drive !== drive_expected[0]) begin
            $display("%0t: drive expected %0d actual %0d", $time,
                     drive_expected[0], out_ch.drive);
            errors++;
          end
          void'(drive_expected.pop_front());
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL pid_controller_clamped_decay");
        $finish;
      end
    end
  end

  task automatic write_reg(input pcd_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pcd_pkg::REG_GAIN_P:           kp = longint'($signed(val));
      pcd_pkg::REG_GAIN_I:           ki = longint'($signed(val));
      pcd_pkg::REG_GAIN_D:           kd = longint'($signed(val));
      pcd_pkg::REG_STEP_TIME:        period = val[30:0];
      pcd_pkg::REG_INTEGRAL_LIMIT:   int_lim = val[30:0];
      pcd_pkg::REG_DERIVATIVE_LIMIT: der_lim = val[30:0];
      pcd_pkg::REG_OUTPUT_WEIGHT:    weight = longint'($signed(val));
      default:                       enables = val[1:0];
    endcase
  endtask

  task automatic push_item(input logic m, input logic [31:0] e);
    pcd_tb_pkg::ctl_item_t it;
    it.mode = m;
    it.error_sample = e;
    pending_items.push_back(it);
  endtask

  // Waits until all items are taken and every drive has arrived.
  task automatic drain();
    while (pending_items.size() != 0 || in_ch.valid || drive_expected.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Mostly small errors so the loop stays in range; some extremes.
  function automatic logic [31:0] rand_error();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(4 * 65536)) - 2 * 65536;
    endcase
  endfunction

  initial begin
    kp = 0; ki = 0; kd = 0; weight = 65536;
    period = 65536; int_lim = 32'h7fffffff; der_lim = 32'h7fffffff;
    enables = 2'b00;
    prev_err = 0; integ = 0; seen_sample = 0;
    errors = 0; calm = 0; cycles = 0; in_taken = 0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = pcd_pkg::REG_GAIN_P; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.mode = 1'b0; in_ch.error_sample = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: first sample at reset gains, then extremes and clears.
    push_item(1'b0, 32'h00010000);
    drain();
    write_reg(pcd_pkg::REG_GAIN_P, 32'h00010000);
    write_reg(pcd_pkg::REG_GAIN_I, 32'h00008000);
    write_reg(pcd_pkg::REG_GAIN_D, 32'h00004000);
    write_reg(pcd_pkg::REG_LIMIT_ENABLES, 2'b11);
    write_reg(pcd_pkg::REG_INTEGRAL_LIMIT, 32'h00030000);
    write_reg(pcd_pkg::REG_DERIVATIVE_LIMIT, 32'h00020000);
    push_item(1'b0, 32'h7fffffff);
    push_item(1'b0, 32'h80000000);
    push_item(1'b1, 32'hffffffff);
    push_item(1'b0, 32'h00050000);
    push_item(1'b0, 32'h00050000);
    push_item(1'b0, 32'hfffb0000);
    push_item(1'b0, 32'h00000000);
    drain();
    // Zero period, extreme P gain and output weight.
    write_reg(pcd_pkg::REG_STEP_TIME, 32'h0);
    write_reg(pcd_pkg::REG_OUTPUT_WEIGHT, 32'h80000000);
    write_reg(pcd_pkg::REG_GAIN_P, 32'h7fffffff);
    push_item(1'b0, 32'h00000001);
    push_item(1'b0, 32'hffffffff);
    push_item(1'b0, 32'h7fffffff);
    drain();
    write_reg(pcd_pkg::REG_STEP_TIME, 32'h7fffffff);
    write_reg(pcd_pkg::REG_OUTPUT_WEIGHT, 32'h7fffffff);
    write_reg(pcd_pkg::REG_GAIN_P, 32'h80000000);
    write_reg(pcd_pkg::REG_INTEGRAL_LIMIT, 32'h0);
    write_reg(pcd_pkg::REG_DERIVATIVE_LIMIT, 32'h0);
    push_item(1'b0, 32'h80000000);
    push_item(1'b0, 32'h12345678);
    push_item(1'b1, 32'h0);
    push_item(1'b0, 32'hedcba987);
    drain();

    // Random phases with fresh settings between them.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(pcd_pkg::REG_GAIN_P, rand_gain());
      write_reg(pcd_pkg::REG_GAIN_I, rand_gain());
      write_reg(pcd_pkg::REG_GAIN_D, rand_gain());
      write_reg(pcd_pkg::REG_STEP_TIME, ph == 3 ? 32'h0 :
                $urandom_range(3) == 0 ? $urandom() : $urandom_range(1, 131072));
      write_reg(pcd_pkg::REG_INTEGRAL_LIMIT,
                $urandom_range(1) ? $urandom_range(20 * 65536) : $urandom());
      write_reg(pcd_pkg::REG_DERIVATIVE_LIMIT,
                $urandom_range(1) ? $urandom_range(20 * 65536) : $urandom());
      write_reg(pcd_pkg::REG_OUTPUT_WEIGHT, rand_gain());
      write_reg(pcd_pkg::REG_LIMIT_ENABLES, $urandom_range(3));
      calm = (ph == 5);
      for (int n = 0; n < 50; n++)
        push_item($urandom_range(9) == 0, rand_error());
      drain();
    end

    if (errors == 0) begin
      $display("PASS pid_controller_clamped_decay");
    end else begin
      $display("FAIL pid_controller_clamped_decay");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pcd_pkg.sv
rtl/core/pcd_if.sv
rtl/core/pcd_mul.sv
rtl/core/pcd_div.sv
rtl/core/pid_controller_clamped_decay.sv
tb/pcd_tb_if.sv
tb/testbench.sv
